// ===== sv/mrc_pkg.sv =====
`timescale 1ns / 1ps

package mrc_pkg;

    localparam int CountBitsDef = 32;

    localparam logic [2:0] RegPThreshold   = 3'd0;
    localparam logic [2:0] RegMergeDist    = 3'd1;
    localparam logic [2:0] RegMinSites     = 3'd2;
    localparam logic [2:0] RegMinLength    = 3'd3;
    localparam logic [2:0] RegMinFraction  = 3'd4;

    localparam logic [31:0] PThresholdRst  = 32'd214748365;
    localparam logic [30:0] MergeDistRst   = 31'd100;
    localparam logic [15:0] MinSitesRst    = 16'd3;
    localparam logic [30:0] MinLengthRst   = 31'd50;
    localparam logic [16:0] MinFractionRst = 17'd32768;

    typedef struct packed {
        logic [30:0]        position;
        logic [31:0]        pvalue;
        logic signed [31:0] test_stat;
        logic signed [31:0] delta;
        logic               chrom_end;
    } t_site;

    typedef struct packed {
        logic [30:0]        region_start;
        logic [30:0]        region_end;
        logic [31:0]        total_sites;
        logic [31:0]        sig_sites;
        logic [16:0]        sig_fraction;
        logic signed [63:0] area;
        logic signed [31:0] mean_statistic;
        logic signed [31:0] mean_delta;
        logic               is_hyper;
        logic [31:0]        min_pvalue;
        logic [31:0]        mean_pvalue;
        logic               last_of_run;
    } t_region;

    // Signed 64-bit accumulate of a 32-bit term, clamped at the 64-bit limits.
    function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                     logic signed [31:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag64(logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    // Quotient magnitude back to a signed 32-bit mean, clamped.
    function automatic logic [31:0] clamp_mean(logic [63:0] q, logic neg);
        logic [63:0] qq;
        if (!neg) begin
            return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        qq = (q > 64'h8000_0000) ? 64'h8000_0000 : q;
        return 32'd0 - qq[31:0];
    endfunction

endpackage

// ===== sv/methylation_region_caller.sv =====
`timescale 1ns / 1ps

// Region caller for position-sorted methylation sites of one chromosome. A site
// is one transaction on the input channel; regions leave one transaction each on
// the output channel, at most three per site, the last flagged by last_of_run.
// Each site passes an update step, then steps through the closing order, then a
// finishing step. A closed cluster that passes the count and length tests runs
// through one shared restoring divider, one quotient bit per cycle: first for
// the fraction, unless all sites are significant, and then, once the fraction
// test passes, for the mean statistic, the mean delta and the mean p-value of
// the emitted region. A stalled output can hold the block in its push and
// finishing steps. The input stall stays high while a site is being worked on.
// Configuration writes are always taken.
module methylation_region_caller import mrc_pkg::*; #(
    parameter int COUNT_BITS = CountBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_site       i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_region     o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int CB = COUNT_BITS;
    localparam logic [CB-1:0] CntMax = '1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD  = 4'd1;
    localparam logic [3:0] S_NEXT = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_DONE = 4'd5;
    localparam logic [3:0] S_FCHK = 4'd6;
    localparam logic [3:0] S_PUSH = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    localparam logic [1:0] OP_FRAC  = 2'd0;
    localparam logic [1:0] OP_STAT  = 2'd1;
    localparam logic [1:0] OP_DELTA = 2'd2;
    localparam logic [1:0] OP_PVAL  = 2'd3;

    typedef struct packed {
        logic               open;
        logic [30:0]        first;
        logic [30:0]        last;
        logic [CB-1:0]      mcnt;
        logic [CB-1:0]      span;
        logic [CB-1:0]      tot;
        logic signed [63:0] ssum;
        logic signed [63:0] dsum;
        logic [63:0]        psum;
        logic [31:0]        pmin;
    } t_grp;

    logic [31:0] r_thr;
    logic [30:0] r_merge;
    logic [15:0] r_min_sites;
    logic [30:0] r_min_len;
    logic [16:0] r_min_frac;

    logic [3:0]  r_state;
    t_site       r_in;
    t_grp        r_grp [2];
    t_grp        r_cb;
    logic        r_cb_pend;
    t_grp        r_cw;
    logic [1:0]  r_csel;

    logic [63:0]   r_dvd;
    logic [CB-1:0] r_dvs;
    logic [CB-1:0] r_rem;
    logic [6:0]    r_cnt;
    logic [1:0]    r_op;
    logic          r_neg;

    logic [16:0] r_frac;
    logic [31:0] r_ms;
    logic [31:0] r_md;
    logic [31:0] r_mp;

    t_region r_hold;
    logic    r_hold_v;
    t_region r_out;
    logic    r_ov;

    t_grp        n_grp [2];
    t_grp        n_cb;
    logic        n_cb_pend;
    t_grp        cur;
    logic        sig;
    logic        gsel;
    logic        join_ok;

    logic [CB:0]   rem_sh;
    logic          div_ge;
    logic [CB:0]   rem_nx;
    logic [31:0]   len;
    logic          pre_ok;
    logic [63:0]   tot64;
    logic [63:0]   mcnt64;
    t_region       res;
    logic          out_free;
    logic          out_load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign out_free    = !r_ov || !i_out_stall;
    assign out_load    = r_hold_v && out_free && (r_state == S_PUSH || r_state == S_FIN);

    // Cluster update for the registered site.
    always_comb begin
        n_grp     = r_grp;
        n_cb      = r_cb;
        n_cb_pend = 1'b0;
        for (int g = 0; g < 2; g++) begin
            if (n_grp[g].open && n_grp[g].span != CntMax) begin
                n_grp[g].span = n_grp[g].span + 1'b1;
            end
        end
        sig     = r_in.pvalue < r_thr;
        gsel    = r_in.test_stat[31];
        cur     = n_grp[gsel];
        join_ok = cur.open && (r_in.position <= cur.last ||
                               (r_in.position - cur.last) <= r_merge);
        if (sig) begin
            if (join_ok) begin
                if (r_in.position > cur.last) begin
                    cur.last = r_in.position;
                end
                if (cur.mcnt != CntMax) begin
                    cur.mcnt = cur.mcnt + 1'b1;
                end
                cur.tot  = cur.span;
                cur.ssum = sat_add64(cur.ssum, r_in.test_stat);
                cur.dsum = sat_add64(cur.dsum, r_in.delta);
                cur.psum = (cur.psum > ~64'(r_in.pvalue)) ? '1 : cur.psum + 64'(r_in.pvalue);
                if (r_in.pvalue < cur.pmin) begin
                    cur.pmin = r_in.pvalue;
                end
            end else begin
                if (cur.open) begin
                    n_cb      = cur;
                    n_cb_pend = 1'b1;
                end
                cur.open  = 1'b1;
                cur.first = r_in.position;
                cur.last  = r_in.position;
                cur.mcnt  = CB'(1);
                cur.span  = CB'(1);
                cur.tot   = CB'(1);
                cur.ssum  = 64'(r_in.test_stat);
                cur.dsum  = 64'(r_in.delta);
                cur.psum  = 64'(r_in.pvalue);
                cur.pmin  = r_in.pvalue;
            end
            n_grp[gsel] = cur;
        end
    end

    always_comb begin
        rem_sh = {r_rem, r_dvd[63]};
        div_ge = rem_sh >= {1'b0, r_dvs};
        rem_nx = div_ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
        len    = {1'b0, r_cw.last} - {1'b0, r_cw.first} + 32'd1;
        tot64  = 64'(r_cw.tot);
        mcnt64 = 64'(r_cw.mcnt);
        pre_ok = (tot64 != 64'd0) && (mcnt64 != 64'd0) &&
                 (mcnt64 >= 64'(r_min_sites)) && (len >= {1'b0, r_min_len});
        res.region_start   = r_cw.first;
        res.region_end     = r_cw.last;
        res.total_sites    = tot64[31:0];
        res.sig_sites      = mcnt64[31:0];
        res.sig_fraction   = r_frac;
        res.area           = r_cw.ssum;
        res.mean_statistic = r_ms;
        res.mean_delta     = r_md;
        res.is_hyper       = (r_ms != 32'd0) && !r_ms[31];
        res.min_pvalue     = r_cw.pmin;
        res.mean_pvalue    = r_mp;
        res.last_of_run    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr         <= PThresholdRst;
            r_merge       <= MergeDistRst;
            r_min_sites   <= MinSitesRst;
            r_min_len     <= MinLengthRst;
            r_min_frac    <= MinFractionRst;
            r_state       <= S_IDLE;
            r_grp[0].open <= 1'b0;
            r_grp[1].open <= 1'b0;
            r_cb_pend     <= 1'b0;
            r_hold_v      <= 1'b0;
            r_ov          <= 1'b0;
            r_cnt         <= 7'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegPThreshold:  r_thr       <= i_cfg_data;
                    RegMergeDist:   r_merge     <= i_cfg_data[30:0];
                    RegMinSites:    r_min_sites <= i_cfg_data[15:0];
                    RegMinLength:   r_min_len   <= i_cfg_data[30:0];
                    RegMinFraction: r_min_frac  <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_grp[0]  <= n_grp[0];
                    r_grp[1]  <= n_grp[1];
                    r_cb      <= n_cb;
                    r_cb_pend <= n_cb_pend;
                    r_csel    <= 2'd0;
                    r_state   <= S_NEXT;
                end
                S_NEXT: begin
                    // Closing order: the cluster the site displaced, then hyper, then hypo.
                    case (r_csel)
                        2'd0: begin
                            r_csel <= 2'd1;
                            if (r_cb_pend) begin
                                r_cw      <= r_cb;
                                r_cb_pend <= 1'b0;
                                r_state   <= S_CHK;
                            end
                        end
                        2'd1: begin
                            r_csel <= 2'd2;
                            if (r_in.chrom_end && r_grp[0].open) begin
                                r_cw          <= r_grp[0];
                                r_grp[0].open <= 1'b0;
                                r_state       <= S_CHK;
                            end
                        end
                        2'd2: begin
                            r_csel <= 2'd3;
                            if (r_in.chrom_end && r_grp[1].open) begin
                                r_cw          <= r_grp[1];
                                r_grp[1].open <= 1'b0;
                                r_state       <= S_CHK;
                            end
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_CHK: begin
                    if (!pre_ok) begin
                        r_state <= S_NEXT;
                    end else if (r_cw.mcnt >= r_cw.tot) begin
                        r_frac  <= 17'd65536;
                        r_state <= S_FCHK;
                    end else begin
                        r_dvd   <= mcnt64 << 16;
                        r_dvs   <= r_cw.tot;
                        r_rem   <= '0;
                        r_cnt   <= 7'd64;
                        r_op    <= OP_FRAC;
                        r_state <= S_DIV;
                    end
                end
                S_FCHK: begin
                    if (r_frac >= r_min_frac) begin
                        r_dvd   <= mag64(r_cw.ssum);
                        r_neg   <= r_cw.ssum[63];
                        r_dvs   <= r_cw.mcnt;
                        r_rem   <= '0;
                        r_cnt   <= 7'd64;
                        r_op    <= OP_STAT;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_DIV: begin
                    r_rem <= rem_nx[CB-1:0];
                    r_dvd <= {r_dvd[62:0], div_ge};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    case (r_op)
                        OP_FRAC: begin
                            r_frac  <= r_dvd[16:0];
                            r_state <= S_FCHK;
                        end
                        OP_STAT: begin
                            r_ms    <= clamp_mean(r_dvd, r_neg);
                            r_dvd   <= mag64(r_cw.dsum);
                            r_neg   <= r_cw.dsum[63];
                            r_rem   <= '0;
                            r_cnt   <= 7'd64;
                            r_op    <= OP_DELTA;
                            r_state <= S_DIV;
                        end
                        OP_DELTA: begin
                            r_md    <= clamp_mean(r_dvd, r_neg);
                            r_dvd   <= r_cw.psum;
                            r_neg   <= 1'b0;
                            r_rem   <= '0;
                            r_cnt   <= 7'd64;
                            r_op    <= OP_PVAL;
                            r_state <= S_DIV;
                        end
                        default: begin
                            r_mp    <= (r_dvd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r_dvd[31:0];
                            r_state <= S_PUSH;
                        end
                    endcase
                end
                S_PUSH: begin
                    // One region stays held back until we know whether it is the last.
                    if (!r_hold_v) begin
                        r_hold   <= res;
                        r_hold_v <= 1'b1;
                        r_state  <= S_NEXT;
                    end else if (out_free) begin
                        r_out   <= r_hold;
                        r_hold  <= res;
                        r_state <= S_NEXT;
                    end
                end
                S_FIN: begin
                    if (!r_hold_v) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        // The lowest bit of a region is last_of_run.
                        r_out    <= {r_hold[$bits(t_region)-1:1], 1'b1};
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held region left behind at idle");

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_UPD))
        else $error("accepted site not processed");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 7'd0 && r_cnt <= 7'd64))
        else $error("divider step count out of range");

    a_open_members: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grp[0].open |-> (r_grp[0].mcnt != '0))
        else $error("open cluster without members");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mrc_pkg::*;

    localparam logic [2:0] RegUnused = 3'd7;
    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned DrainCycles = 300;

    // Tracks the region caller: configuration, per-direction cluster state and
    // the regions still owed by the block.
    class region_scoreboard;
        logic [31:0] p_thr;
        logic [30:0] merge_dist;
        logic [15:0] min_sites;
        logic [30:0] min_len;
        logic [16:0] min_frac;

        bit                 open_c[2];
        longint unsigned    first_pos[2], last_pos[2];
        longint unsigned    members[2], span[2], total_last[2];
        longint             stat_acc[2], delta_acc[2];
        longint unsigned    pv_acc[2], pv_min[2];

        t_region pending_regions[$];
        t_region fresh[$];
        int unsigned errors;
        int unsigned regions_seen;

        function new();
            p_thr = PThresholdRst;
            merge_dist = MergeDistRst;
            min_sites = MinSitesRst;
            min_len = MinLengthRst;
            min_frac = MinFractionRst;
            for (int g = 0; g < 2; g++) begin
                clear_cluster(g);
            end
            errors = 0;
            regions_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                RegPThreshold:  p_thr = data;
                RegMergeDist:   merge_dist = data[30:0];
                RegMinSites:    min_sites = data[15:0];
                RegMinLength:   min_len = data[30:0];
                RegMinFraction: min_frac = data[16:0];
                default: ;
            endcase
        endfunction

        function void clear_cluster(int g);
            open_c[g] = 0;
            first_pos[g] = 0;
            last_pos[g] = 0;
            members[g] = 0;
            span[g] = 0;
            total_last[g] = 0;
            stat_acc[g] = 0;
            delta_acc[g] = 0;
            pv_acc[g] = 0;
            pv_min[g] = 0;
        endfunction

        function longint sat_sum(longint a, longint b);
            longint hi, lo;
            hi = 64'h7FFF_FFFF_FFFF_FFFF;
            lo = 64'h8000_0000_0000_0000;
            if (b > 0 && a > hi - b) return hi;
            if (b < 0 && a < lo - b) return lo;
            return a + b;
        endfunction

        function logic [31:0] trunc_mean(longint a, longint unsigned n);
            bit neg;
            longint unsigned mag, q;
            neg = a < 0;
            mag = a;
            if (neg) mag = 64'd0 - mag;
            q = (n != 0) ? mag / n : 0;
            if (!neg && q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            if (neg && q > 64'h8000_0000) q = 64'h8000_0000;
            if (neg) q = 64'd0 - q;
            return q[31:0];
        endfunction

        function void close_cluster(int g);
            longint unsigned nsig, ntot, len, frac, mp;
            t_region r;
            if (!open_c[g]) return;
            nsig = members[g];
            ntot = total_last[g];
            len = last_pos[g] - first_pos[g] + 1;
            if (ntot == 0) frac = 0;
            else if (nsig >= ntot) frac = 65536;
            else frac = (nsig << 16) / ntot;
            if (ntot != 0 && nsig != 0 && nsig >= min_sites && len >= min_len &&
                frac >= min_frac) begin
                r.region_start = first_pos[g][30:0];
                r.region_end = last_pos[g][30:0];
                r.total_sites = ntot[31:0];
                r.sig_sites = nsig[31:0];
                r.sig_fraction = frac[16:0];
                r.area = stat_acc[g];
                r.mean_statistic = trunc_mean(stat_acc[g], nsig);
                r.mean_delta = trunc_mean(delta_acc[g], nsig);
                r.is_hyper = (r.mean_statistic != 0) && !r.mean_statistic[31];
                r.min_pvalue = pv_min[g][31:0];
                mp = pv_acc[g] / nsig;
                r.mean_pvalue = (mp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mp[31:0];
                r.last_of_run = 0;
                fresh.insert(fresh.size(), r);
            end
            clear_cluster(g);
        endfunction

        function void note_site(t_site s);
            longint unsigned p, pv;
            longint st, dl;
            int g;
            p = s.position;
            pv = s.pvalue;
            st = s.test_stat;
            dl = s.delta;
            fresh.delete();
            for (g = 0; g < 2; g++) begin
                if (open_c[g] && span[g] < 64'hFFFF_FFFF) span[g]++;
            end
            if (pv < p_thr) begin
                g = (st >= 0) ? 0 : 1;
                if (open_c[g] && (p <= last_pos[g] || p - last_pos[g] <= merge_dist)) begin
                    if (p > last_pos[g]) last_pos[g] = p;
                    if (members[g] < 64'hFFFF_FFFF) members[g]++;
                    total_last[g] = span[g];
                    stat_acc[g] = sat_sum(stat_acc[g], st);
                    delta_acc[g] = sat_sum(delta_acc[g], dl);
                    pv_acc[g] = (pv_acc[g] > ~64'd0 - pv) ? ~64'd0 : pv_acc[g] + pv;
                    if (pv < pv_min[g]) pv_min[g] = pv;
                end else begin
                    close_cluster(g);
                    open_c[g] = 1;
                    first_pos[g] = p;
                    last_pos[g] = p;
                    members[g] = 1;
                    span[g] = 1;
                    total_last[g] = 1;
                    stat_acc[g] = st;
                    delta_acc[g] = dl;
                    pv_acc[g] = pv;
                    pv_min[g] = pv;
                end
            end
            if (s.chrom_end) begin
                close_cluster(0);
                close_cluster(1);
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last_of_run = 1;
            foreach (fresh[i]) pending_regions.insert(pending_regions.size(), fresh[i]);
        endfunction

        function void check_region(t_region got);
            t_region want;
            regions_seen++;
            if (pending_regions.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected region: %p", got);
                return;
            end
            want = pending_regions.pop_front();
            if (want.region_start !== got.region_start || want.region_end !== got.region_end ||
                want.total_sites !== got.total_sites || want.sig_sites !== got.sig_sites ||
                want.sig_fraction !== got.sig_fraction || want.area !== got.area ||
                want.mean_statistic !== got.mean_statistic ||
                want.mean_delta !== got.mean_delta || want.is_hyper !== got.is_hyper ||
                want.min_pvalue !== got.min_pvalue || want.mean_pvalue !== got.mean_pvalue ||
                want.last_of_run !== got.last_of_run) begin
                errors++;
                if (errors <= 10) begin
                    $display("region mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    t_site       i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    t_region     o_out;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    region_scoreboard sb = new();
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned cycles = 0;
    int unsigned sites_sent = 0;
    longint unsigned cur_pos = 0;

    methylation_region_caller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: take a region whenever valid and not stalled, then pick the
    // stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_region(o_out);
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic t_site mk(longint unsigned pos, logic [31:0] pv, logic [31:0] st,
                                 logic [31:0] dl, logic ce);
        t_site s;
        s.position = pos[30:0];
        s.pvalue = pv;
        s.test_stat = st;
        s.delta = dl;
        s.chrom_end = ce;
        return s;
    endfunction

    task automatic send_site(t_site s);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= s;
        i_in_valid <= 1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_site(s);
        sites_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 0;
        while (sb.pending_regions.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic setup(logic [31:0] thr, logic [31:0] md, logic [31:0] ms,
                         logic [31:0] ml, logic [31:0] mf);
        wait_idle();
        // Upper bits beyond the narrower registers' widths are random and must be dropped.
        write_reg(RegPThreshold, thr);
        write_reg(RegMergeDist, {1'($urandom_range(1)), md[30:0]});
        write_reg(RegMinSites, {16'($urandom), ms[15:0]});
        write_reg(RegMinLength, {1'($urandom_range(1)), ml[30:0]});
        write_reg(RegMinFraction, {15'($urandom), mf[16:0]});
        write_reg(RegUnused, $urandom);
    endtask

    task automatic random_site(output t_site s);
        longint unsigned step, mg;
        logic [31:0] pv, st;
        if ($urandom_range(99) < 85) begin
            mg = sb.merge_dist;
            case ($urandom_range(9))
                0: step = mg;
                1: step = mg + 1;
                2: step = $urandom_range(1000, 100000);
                default: step = $urandom_range(1, (mg > 200) ? 200 : mg + 1);
            endcase
            if (step == 0) step = 1;
            if (cur_pos + step > 64'h7FFF_FFFF) cur_pos = $urandom_range(1000);
            if ($urandom_range(99) < 75 && sb.p_thr != 0) pv = $urandom_range(sb.p_thr - 1, 0);
            else pv = $urandom_range(32'hFFFF_FFFF, sb.p_thr);
            case ($urandom_range(19))
                0: st = 32'h7FFF_FFFF;
                1: st = 32'h8000_0000;
                2: st = 0;
                default: st = $urandom_range(32'h0004_0000);
            endcase
            if ($urandom_range(1)) st = 32'd0 - st;
            s = mk(cur_pos + step, pv, st, $urandom, $urandom_range(99) < 4);
        end else begin
            s = mk({$urandom, $urandom}, $urandom, $urandom, $urandom,
                   $urandom_range(99) < 10);
        end
        cur_pos = s.chrom_end ? $urandom_range(1000) : s.position;
    endtask

    task automatic random_sites(int unsigned n);
        t_site s;
        repeat (n) begin
            random_site(s);
            send_site(s);
        end
    endtask

    initial begin
        t_site dir[$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Everything passes here, so each closed cluster shows up as a region.
        setup(32'hFFFF_FFFF, 10, 0, 0, 0);
        dir.insert(dir.size(), mk(0, 0, 0, 0, 0));
        dir.insert(dir.size(), mk(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 0));
        dir.insert(dir.size(), mk(8, 1, 32'h8000_0000, 32'h8000_0000, 0));
        dir.insert(dir.size(), mk(3, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        dir.insert(dir.size(), mk(20, 32'h10, 5, 7, 0));
        dir.insert(dir.size(), mk(30, 3, -5, -7, 1));
        dir.insert(dir.size(), mk(100, 32'hFFFF_FFFF, 0, 0, 1));
        dir.insert(dir.size(),
                   mk(31'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        dir.insert(dir.size(), mk(31'h7FFF_FFF5, 0, 32'h8000_0000, 0, 1));
        dir.insert(dir.size(), mk(10, 0, -1, -1, 0));
        dir.insert(dir.size(), mk(15, 9, -3, -2, 0));
        dir.insert(dir.size(), mk(20, 4, -4, 32'h7FFF_FFFF, 1));
        dir.insert(dir.size(), mk(200, 0, 0, 0, 0));
        dir.insert(dir.size(), mk(205, 0, 0, 0, 1));
        dir.insert(dir.size(), mk(300, 7, 1, 1, 0));
        dir.insert(dir.size(), mk(310, 7, 1, 1, 0));
        dir.insert(dir.size(), mk(321, 7, 1, 1, 1));
        foreach (dir[i]) send_site(dir[i]);
        cur_pos = 0;
        random_sites(60);

        setup(PThresholdRst, MergeDistRst, MinSitesRst, MinLengthRst, MinFractionRst);
        send_idle_pct = 88;
        random_sites(50);
        // Hold the sender until the block has handed back all owed regions.
        wait_idle();
        random_sites(50);

        setup(32'h8000_0000, 1000, 2, 1, 65536);
        send_idle_pct = 0;
        stall_pct = 88;
        random_sites(100);

        setup(32'h4000_0000, 31'h7FFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF, 17'h1FFFF);
        stall_pct = 0;
        random_sites(30);

        setup(32'h1000_0000, 500, 1, 20, 20000);
        send_idle_pct = 11;
        stall_pct = 11;
        random_sites(90);

        i_in_valid <= 0;
        while (sb.pending_regions.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        $display("Sent %0d sites over five register settings, checked %0d regions.",
                 sites_sent, sb.regions_seen);
        $display("Sender and receiver idling varied per phase; %0d mismatches.", sb.errors);
        if (sb.errors == 0 && sb.pending_regions.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
